/* sv/efr_pkg.sv */
package efr_pkg;

	// Default store depth.
	localparam int FRAME_BYTES_DEF = 160;

	// Framing bytes.
	localparam logic [7:0] SYNC_A   = 8'h55;
	localparam logic [7:0] SYNC_B   = 8'hAA;
	localparam logic [7:0] ESC_BYTE = 8'hF0;

	// Request codes.
	localparam logic [1:0] REQ_RX    = 2'd0;
	localparam logic [1:0] REQ_READ  = 2'd1;
	localparam logic [1:0] REQ_CLEAR = 2'd2;

	typedef enum logic [1:0] {
		EVT_NONE     = 2'd0,
		EVT_DONE     = 2'd1,
		EVT_OVERFLOW = 2'd2,
		EVT_READ     = 2'd3
	} evt_t;

	// Result fields decided in the processing stage.
	typedef struct packed {
		evt_t       event_code;
		logic [7:0] command_byte;
		logic [7:0] raw_length;
		logic [7:0] frame_length;
		logic       id_length_bad;
	} res_t;

endpackage

/* sv/efr_ram.sv */
module efr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 160,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

/* sv/efr_deframer.sv */
module efr_deframer #(
	parameter int FRAME_BYTES = efr_pkg::FRAME_BYTES_DEF,
	localparam int AW = $clog2(FRAME_BYTES)
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                go,
	input  logic [1:0]          req_type,
	input  logic [7:0]          rx_byte,
	input  logic [7:0]          read_index,
	output efr_pkg::res_t       res,
	output logic                wr_en,
	output logic [AW-1:0]       wr_addr,
	output logic [7:0]          wr_data,
	output logic                rd_en,
	output logic [AW-1:0]       rd_addr
);

	import efr_pkg::*;

	localparam int CW = $clog2(FRAME_BYTES + 1);
	localparam logic [CW-1:0] LIMIT = CW'(FRAME_BYTES);
	localparam logic [8:0] LIMIT9 = 9'(FRAME_BYTES);

	logic [CW-1:0] raw_q, stored_q;
	logic          esc_q;
	logic [7:0]    prev_q, cmd_q;

	logic [CW-1:0] raw_d, stored_d, pos;
	logic          esc_d;
	logic [7:0]    prev_d, cmd_d;
	logic          put;
	logic [7:0]    put_val;
	logic          room;

	assign pos     = raw_q + CW'(1);
	assign room    = stored_q < LIMIT;
	assign rd_addr = read_index[AW-1:0];
	assign wr_addr = stored_q[AW-1:0];
	assign wr_data = put_val;
	assign wr_en   = go && put && room;

	always_comb begin
		raw_d    = raw_q;
		stored_d = stored_q;
		esc_d    = esc_q;
		prev_d   = prev_q;
		cmd_d    = cmd_q;
		put      = 1'b0;
		put_val  = rx_byte;
		rd_en    = 1'b0;
		res      = '0;

		unique case (req_type)
			REQ_READ: begin
				if ({1'b0, read_index} < LIMIT9) begin
					rd_en          = go;
					res.event_code = EVT_READ;
				end
			end
			REQ_CLEAR: begin
				raw_d    = '0;
				stored_d = '0;
				esc_d    = 1'b0;
			end
			REQ_RX: begin
				prev_d = rx_byte;
				if (pos == CW'(1) || pos == CW'(2)) begin
					// Header: drop a wrong sync byte and restart
					if ((pos == CW'(1) && rx_byte != SYNC_A) ||
					    (pos == CW'(2) && rx_byte != SYNC_B)) begin
						raw_d    = '0;
						stored_d = '0;
						esc_d    = 1'b0;
					end else begin
						raw_d = pos;
						put   = 1'b1;
					end
				end else begin
					raw_d = pos;
					if (esc_q) begin
						put     = 1'b1;
						put_val = rx_byte ^ ESC_BYTE;
						esc_d   = 1'b0;
					end else if (rx_byte == ESC_BYTE) begin
						esc_d = 1'b1;
					end else begin
						put = 1'b1;
					end
				end

				if (put && room) begin
					stored_d = stored_q + CW'(1);
					if (stored_q == CW'(2)) begin
						cmd_d = put_val;
					end
				end

				if (pos > CW'(2)) begin
					if (pos >= LIMIT) begin
						res.event_code = EVT_OVERFLOW;
						raw_d          = '0;
						stored_d       = '0;
						esc_d          = 1'b0;
					end else if (prev_q == SYNC_B && rx_byte == SYNC_A) begin
						res.event_code    = EVT_DONE;
						res.command_byte  = cmd_d;
						res.raw_length    = 8'(pos);
						res.frame_length  = 8'(stored_d);
						res.id_length_bad = (cmd_d == 8'd0) && (pos != CW'(5));
						raw_d             = '0;
						stored_d          = '0;
						esc_d             = 1'b0;
					end
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			raw_q    <= '0;
			stored_q <= '0;
			esc_q    <= 1'b0;
			prev_q   <= '0;
			cmd_q    <= '0;
		end else if (go) begin
			raw_q    <= raw_d;
			stored_q <= stored_d;
			esc_q    <= esc_d;
			prev_q   <= prev_d;
			cmd_q    <= cmd_d;
		end
	end

endmodule

/* sv/escaped_frame_receiver.sv */
// An accepted item waits in the input register, then passes through the processing
// stage into the result register, where it is held until the output handshake.
// Throughput: one item per cycle, set by the single processing stage and the
// store's one write and one read port; output stalls hold the pipeline.
// Reset (arst_n, asynchronous) empties the pipeline, clears all framing state and
// marks every store entry unwritten, so it reads as zero straight after reset.
module escaped_frame_receiver #(
	parameter int FRAME_BYTES = efr_pkg::FRAME_BYTES_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [1:0] req_type,
	input  logic [7:0] rx_byte,
	input  logic [7:0] read_index,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [1:0] event_code,
	output logic [7:0] command_byte,
	output logic [7:0] raw_length,
	output logic [7:0] frame_length,
	output logic       id_length_bad,
	output logic [7:0] read_data
);

	import efr_pkg::*;

	localparam int AW = $clog2(FRAME_BYTES);

	// Input register: holds the accepted item while it is processed.
	logic       valid_s1;
	logic [1:0] req_type_s1;
	logic [7:0] rx_byte_s1;
	logic [7:0] read_index_s1;

	// Result register.
	logic       valid_s2;
	res_t       res_s2;
	logic       hit_s2;

	logic          go;
	res_t          res;
	logic          wr_en, rd_en;
	logic [AW-1:0] wr_addr, rd_addr;
	logic [7:0]    wr_data, rd_data;

	// Per-entry written marks: an entry never written reads as zero.
	logic [FRAME_BYTES-1:0] vld_q;

	// Advance the processing stage when the result register is free or being
	// emptied; this is also the only time framing state and the store change.
	assign go       = valid_s1 && (!valid_s2 || out_ready);
	assign in_ready = !valid_s1 || go;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			valid_s1 <= 1'b1;
		end else if (go) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			req_type_s1   <= req_type;
			rx_byte_s1    <= rx_byte;
			read_index_s1 <= read_index;
		end
	end

	efr_deframer #(
		.FRAME_BYTES(FRAME_BYTES)
	) u_deframer (
		.clk        (clk),
		.arst_n     (arst_n),
		.go         (go),
		.req_type   (req_type_s1),
		.rx_byte    (rx_byte_s1),
		.read_index (read_index_s1),
		.res        (res),
		.wr_en      (wr_en),
		.wr_addr    (wr_addr),
		.wr_data    (wr_data),
		.rd_en      (rd_en),
		.rd_addr    (rd_addr)
	);

	// Frame store: unescaped bytes written on the fly, read back on request.
	// Read data is registered, so it lines up with the result register.
	efr_ram #(
		.WIDTH(8),
		.DEPTH(FRAME_BYTES)
	) u_store (
		.clk   (clk),
		.we    (wr_en),
		.waddr (wr_addr),
		.wdata (wr_data),
		.re    (rd_en),
		.raddr (rd_addr),
		.rdata (rd_data)
	);

	// Mark an entry once written; the marks are never cleared after reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (wr_en) begin
			vld_q[wr_addr] <= 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (go) begin
			valid_s2 <= 1'b1;
		end else if (out_ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			res_s2 <= res;
			hit_s2 <= vld_q[rd_addr];
		end
	end

	assign out_valid     = valid_s2;
	assign event_code    = res_s2.event_code;
	assign command_byte  = res_s2.command_byte;
	assign raw_length    = res_s2.raw_length;
	assign frame_length  = res_s2.frame_length;
	assign id_length_bad = res_s2.id_length_bad;
	// Show store data only on a read result from an entry that has been written.
	assign read_data     = (res_s2.event_code == EVT_READ && hit_s2) ? rd_data : 8'd0;

endmodule

/* sim/tb_escaped_frame_receiver.sv */
module tb_escaped_frame_receiver;

	import efr_pkg::*;

	localparam int STORE_DEPTH     = FRAME_BYTES_DEF;
	localparam int ITEM_TARGET     = 900;
	localparam int HOLD_OFF_CYCLES = 200;
	localparam int DRAIN_CYCLES    = 8;
	localparam int CYCLE_LIMIT     = 200000;

	// The request code that the block has to ignore.
	localparam logic [1:0] REQ_UNUSED = 2'd3;

	logic       clk;
	logic       arst_n;
	logic       in_valid;
	logic       in_ready;
	logic [1:0] req_type;
	logic [7:0] rx_byte;
	logic [7:0] read_index;
	logic       out_valid;
	logic       out_ready;
	logic [1:0] event_code;
	logic [7:0] command_byte;
	logic [7:0] raw_length;
	logic [7:0] frame_length;
	logic       id_length_bad;
	logic [7:0] read_data;

	// One expected result. Fields that mean nothing for the event stay zero.
	typedef struct {
		evt_t       evt;
		logic [7:0] cmd;
		logic [7:0] raw_len;
		logic [7:0] frm_len;
		logic       len_bad;
		logic [7:0] rdata;
	} frame_event_t;

	frame_event_t pending_events[$];

	// The testbench's own copy of the deframer state.
	logic [7:0] shadow_store [STORE_DEPTH];
	int         rx_pos;
	int         kept_count;
	bit         escape_armed;
	logic [7:0] last_raw;
	logic [7:0] cmd_seen;

	int items_taken;
	int results_seen;
	int fail_count;
	int cycle_count;
	int sender_gap_max;
	int taker_stall_max;
	bit hold_off_req;

	escaped_frame_receiver uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.req_type     (req_type),
		.rx_byte      (rx_byte),
		.read_index   (read_index),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.event_code   (event_code),
		.command_byte (command_byte),
		.raw_length   (raw_length),
		.frame_length (frame_length),
		.id_length_bad(id_length_bad),
		.read_data    (read_data)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// ---------------------------------------------------------------- prediction

	function void restart_shadow();
		rx_pos       = 0;
		kept_count   = 0;
		escape_armed = 1'b0;
	endfunction

	// Write one unescaped byte at the next store position. Remember the byte at
	// position 2, since it becomes the command of the frame.
	function void keep_byte(input logic [7:0] v);
		if (kept_count < STORE_DEPTH) begin
			shadow_store[kept_count] = v;
			if (kept_count == 2)
				cmd_seen = v;
			kept_count++;
		end
	endfunction

	function automatic frame_event_t deframe_item(input logic [1:0] req,
			input logic [7:0] b, input logic [7:0] idx);
		frame_event_t r;
		logic [7:0]   prev;
		int           pos;
		r.evt     = EVT_NONE;
		r.cmd     = 8'h00;
		r.raw_len = 8'h00;
		r.frm_len = 8'h00;
		r.len_bad = 1'b0;
		r.rdata   = 8'h00;
		case (req)
			REQ_READ: begin
				if (idx < STORE_DEPTH) begin
					r.evt   = EVT_READ;
					r.rdata = shadow_store[idx];
				end
			end
			REQ_CLEAR: restart_shadow();
			REQ_RX: begin
				prev     = last_raw;
				pos      = rx_pos + 1;
				last_raw = b;
				// Drop a bad header byte and wait for a fresh start.
				if ((pos == 1 && b != SYNC_A) || (pos == 2 && b != SYNC_B)) begin
					restart_shadow();
				end else if (pos <= 2) begin
					rx_pos = pos;
					keep_byte(b);
				end else begin
					rx_pos = pos;
					if (escape_armed) begin
						keep_byte(b ^ ESC_BYTE);
						escape_armed = 1'b0;
					end else if (b == ESC_BYTE) begin
						escape_armed = 1'b1;
					end else begin
						keep_byte(b);
					end
					// Overflow wins over a stop pair on the same byte. The stop
					// pair looks at raw bytes only, escaped or not.
					if (pos >= STORE_DEPTH) begin
						r.evt = EVT_OVERFLOW;
						restart_shadow();
					end else if (prev == SYNC_B && b == SYNC_A) begin
						r.evt     = EVT_DONE;
						r.cmd     = cmd_seen;
						r.raw_len = pos[7:0];
						r.frm_len = kept_count[7:0];
						r.len_bad = (cmd_seen == 8'h00 && pos != 5);
						restart_shadow();
					end
				end
			end
			default: ;
		endcase
		return r;
	endfunction

	// ---------------------------------------------------------------- checking

	task automatic check_field(input string what, input logic [7:0] want,
			input logic [7:0] got);
		if (got !== want) begin
			fail_count++;
			$display("%0t: %s mismatch, expected %0h, actual %0h",
				$time, what, want, got);
		end
	endtask

	// Check the result first, then log the prediction for the item taken at this
	// edge. The item cannot have its result on the outputs at the same edge.
	always @(posedge clk) begin
		frame_event_t want;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				results_seen++;
				if (pending_events.size() == 0) begin
					fail_count++;
					$display("%0t: unexpected result, expected none, actual event %0d",
						$time, event_code);
				end else begin
					want = pending_events.pop_front();
					check_field("event_code", 8'(want.evt), 8'(event_code));
					check_field("command_byte", want.cmd, command_byte);
					check_field("raw_length", want.raw_len, raw_length);
					check_field("frame_length", want.frm_len, frame_length);
					check_field("id_length_bad", 8'(want.len_bad), 8'(id_length_bad));
					check_field("read_data", want.rdata, read_data);
				end
			end
			if (in_valid && in_ready) begin
				pending_events.push_back(deframe_item(req_type, rx_byte, read_index));
				items_taken++;
			end
		end
	end

	// ---------------------------------------------------------------- receiver side

	// Draw a stall before each result. When a hold-off is asked for, keep ready
	// low for a long stretch so that the block backs up to its input.
	initial begin : result_taker
		int stall;
		int seen;
		out_ready = 1'b0;
		wait (arst_n);
		@(negedge clk);
		forever begin
			if (hold_off_req) begin
				hold_off_req = 1'b0;
				out_ready <= 1'b0;
				repeat (HOLD_OFF_CYCLES) @(negedge clk);
			end
			stall = $urandom_range(0, taker_stall_max);
			if (stall != 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			out_ready <= 1'b1;
			seen = results_seen;
			do @(negedge clk); while (results_seen == seen);
		end
	end

	// ---------------------------------------------------------------- sender side

	// Offer one item and hold it until it is taken. Called and returns at a falling
	// edge. Valid stays high between items when no gap is drawn.
	task automatic send_item(input logic [1:0] req, input logic [7:0] b,
			input logic [7:0] idx);
		int gap;
		int taken;
		gap = $urandom_range(0, sender_gap_max);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid   <= 1'b1;
		req_type   <= req;
		rx_byte    <= b;
		read_index <= idx;
		taken = items_taken;
		do @(negedge clk); while (items_taken == taken);
	endtask

	// Fields that the request does not use carry random values.
	task automatic send_rx(input logic [7:0] b);
		send_item(REQ_RX, b, 8'($urandom_range(0, 255)));
	endtask

	task automatic send_read(input logic [7:0] idx);
		send_item(REQ_READ, 8'($urandom_range(0, 255)), idx);
	endtask

	task automatic send_clear();
		send_item(REQ_CLEAR, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
	endtask

	// Send a frame of random body bytes, biased towards the framing bytes. Stuff a
	// byte whenever it would otherwise end the frame early, and now and then at
	// random. A frame that is not closed is left hanging.
	task automatic send_frame(input int body_len, input bit closed);
		logic [7:0] c;
		logic [7:0] last;
		int         k;
		send_rx(SYNC_A);
		send_rx(SYNC_B);
		last = SYNC_B;
		for (k = 0; k < body_len; k++) begin
			case ($urandom_range(0, 5))
				0:       c = SYNC_A;
				1:       c = SYNC_B;
				2:       c = ESC_BYTE;
				default: c = 8'($urandom_range(0, 255));
			endcase
			if (k == 0 && $urandom_range(0, 5) == 0)
				c = 8'h00;
			if (c == ESC_BYTE || (c == SYNC_A && last == SYNC_B) ||
					$urandom_range(0, 9) == 0) begin
				send_rx(ESC_BYTE);
				c = c ^ ESC_BYTE;
			end
			send_rx(c);
			last = c;
		end
		if (closed) begin
			send_rx(SYNC_B);
			send_rx(SYNC_A);
		end
	endtask

	// ---------------------------------------------------------------- tests

	// The store reads as zero after reset. Reads past its end and the unknown
	// request give no event.
	task automatic test_reset_contents();
		send_read(8'd0);
		send_read(8'(STORE_DEPTH - 1));
		send_read(8'(STORE_DEPTH));
		send_read(8'hFF);
		send_item(REQ_UNUSED, 8'hFF, 8'hFF);
	endtask

	// Drop a bad first byte and a bad second byte. A clear part way into the
	// header restarts reception, so the 0xAA that follows is a bad first byte.
	task automatic test_header_errors();
		send_rx(8'h00);
		send_rx(SYNC_A);
		send_rx(8'h13);
		send_rx(SYNC_A);
		send_clear();
		send_rx(SYNC_B);
	endtask

	task automatic test_short_frames();
		// Shortest frame: the 0xAA of the header also opens the stop pair.
		send_rx(SYNC_A);
		send_rx(SYNC_B);
		send_rx(SYNC_A);
		// Stop pair behind an escape: 0x5A and 0x55 are stored.
		send_rx(SYNC_A);
		send_rx(SYNC_B);
		send_rx(ESC_BYTE);
		send_rx(SYNC_B);
		send_rx(SYNC_A);
		send_read(8'd2);
		// Zero command, six raw bytes: the ID length flag is set.
		send_rx(SYNC_A);
		send_rx(SYNC_B);
		send_rx(ESC_BYTE);
		send_rx(ESC_BYTE);
		send_rx(SYNC_B);
		send_rx(SYNC_A);
		send_read(8'd3);
	endtask

	// Fill the frame to the store depth, ending on a stop pair. Overflow must win.
	task automatic test_overflow();
		int k;
		send_rx(SYNC_A);
		send_rx(SYNC_B);
		for (k = 3; k <= STORE_DEPTH - 2; k++)
			send_rx(8'($urandom_range(0, 8'h54)));
		send_rx(SYNC_B);
		send_rx(SYNC_A);
		send_read(8'(STORE_DEPTH - 1));
		send_read(8'd2);
	endtask

	// Hold the receiver off while the sender offers items without gaps.
	task automatic test_backpressure();
		sender_gap_max  = 0;
		taker_stall_max = 0;
		hold_off_req    = 1'b1;
		repeat (4) send_frame($urandom_range(4, 10), 1'b1);
	endtask

	task automatic test_random_traffic();
		int chunk;
		int chunk_end;
		int pick;
		chunk = 0;
		while (items_taken < ITEM_TARGET) begin
			// Cycle through every mix of sender gaps and receiver stalls, and
			// ask for a hold-off now and then.
			sender_gap_max  = (chunk % 4 < 2) ? 5 : 0;
			taker_stall_max = (chunk % 2 == 0) ? 5 : 0;
			if (chunk % 3 == 2)
				hold_off_req = 1'b1;
			chunk_end = items_taken + 120;
			while (items_taken < chunk_end) begin
				pick = $urandom_range(0, 99);
				if (pick < 60)
					send_frame($urandom_range(0, 12), 1'b1);
				else if (pick < 63)
					send_frame($urandom_range(150, 165), 1'b1);
				else if (pick < 68)
					send_frame($urandom_range(0, 8), 1'b0);
				else if (pick < 73)
					send_read(8'($urandom_range(0, 15)));
				else if (pick < 78)
					send_read(8'($urandom_range(0, 255)));
				else if (pick < 83)
					send_clear();
				else if (pick < 86)
					send_item(REQ_UNUSED, 8'($urandom_range(0, 255)),
						8'($urandom_range(0, 255)));
				else
					send_rx(8'($urandom_range(0, 255)));
			end
			chunk++;
		end
	endtask

	// ---------------------------------------------------------------- run

	initial begin : watchdog
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("escaped_frame_receiver test failed");
		$finish;
	end

	initial begin : run_tests
		int k;
		arst_n          = 1'b0;
		in_valid        = 1'b0;
		req_type        = REQ_RX;
		rx_byte         = 8'h00;
		read_index      = 8'h00;
		items_taken     = 0;
		results_seen    = 0;
		fail_count      = 0;
		hold_off_req    = 1'b0;
		sender_gap_max  = 5;
		taker_stall_max = 5;
		for (k = 0; k < STORE_DEPTH; k++)
			shadow_store[k] = 8'h00;
		last_raw = 8'h00;
		cmd_seen = 8'h00;
		restart_shadow();

		repeat (10) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_reset_contents();
		test_header_errors();
		test_short_frames();
		test_overflow();
		test_backpressure();
		test_random_traffic();

		// Drain: wait for every result owed, then keep watching for strays.
		in_valid <= 1'b0;
		while (pending_events.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);

		if (fail_count == 0)
			$display("escaped_frame_receiver test passed");
		else
			$display("escaped_frame_receiver test failed");
		$finish;
	end

endmodule

/* sim.f */
sv/efr_pkg.sv
sv/efr_ram.sv
sv/efr_deframer.sv
sv/escaped_frame_receiver.sv
sim/tb_escaped_frame_receiver.sv
